// ===== sv/rbsa_pkg.sv =====
// Shared constants for the reference-counted bitmap slot allocator.
// Holds command codes, fixed field widths and parameter defaults.
// Depends on nothing.
package rbsa_pkg;

    localparam int MAP_WORDS_DEF  = 16;
    localparam int COUNT_BITS_DEF = 16;

    localparam int CAP_W       = 5;
    localparam int CMD_W       = 2;
    localparam int SLOT_IDX_W  = 10;
    localparam int REF_OUT_W   = 16;
    localparam int USED_W      = 11;
    localparam int WORD_SLOTS  = 64;
    localparam int BIT_IDX_W   = 6;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DROP  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd3;

endpackage

// ===== sv/refcounted_bitmap_slot_allocator.sv =====
// Top level of the reference-counted bitmap slot allocator.
// Depends on rbsa_pkg, rbsa_ram and rbsa_lsb8.
//
// A command transfer is taken at a rising edge where start is high and busy
// is low. The block then works on that one command and keeps busy high until
// it is done. Done is high for exactly one cycle, and the result stays on the
// result ports until the next command; the receiver has no way to stall it.
// Allocate reads the free bitmap one word per cycle upward from the search
// hint. The lowest free bit is found in two steps of one shared eight-way
// priority unit. Allocations that fail at once never raise busy. Add, drop
// and query are one read-modify-write of the bitmap word and the count
// memory; a command on a slot beyond the count memory fails without raising
// busy. After reset a clearing pass writes every bitmap word to all free,
// one word a cycle, with busy high. The capacity register may be written at
// any time the block is idle and resets to 16 words.
module refcounted_bitmap_slot_allocator
    import rbsa_pkg::*;
#(
    parameter int MAP_WORDS  = MAP_WORDS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  capacity_words_we,
    input  logic [CAP_W-1:0]      capacity_words,
    input  logic                  start,
    output logic                  busy,
    input  logic [CMD_W-1:0]      command,
    input  logic [SLOT_IDX_W-1:0] slot_index,
    output logic                  done,
    output logic [SLOT_IDX_W-1:0] granted_slot,
    output logic                  success,
    output logic                  slot_freed,
    output logic [REF_OUT_W-1:0]  ref_count_now
);

    localparam int WORD_BITS = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int NUM_SLOTS = MAP_WORDS * WORD_SLOTS;
    localparam int SLOT_W    = WORD_BITS + BIT_IDX_W;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_FIND1 = 3'd3;
    localparam logic [2:0] ST_FIND2 = 3'd4;
    localparam logic [2:0] ST_OPRD  = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [CAP_W-1:0]      cap_reg;
    logic [WORD_BITS-1:0]  search_reg, search_next;
    logic [USED_W-1:0]     used_reg, used_next;
    logic [WORD_BITS-1:0]  clr_reg, clr_next;
    logic [WORD_BITS-1:0]  word_reg, word_next;
    logic [CMD_W-1:0]      cmd_reg, cmd_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [63:0]           data_reg, data_next;
    logic [2:0]            byte_idx_reg, byte_idx_next;
    logic [7:0]            byte_reg, byte_next;

    logic                  done_reg, done_next;
    logic [SLOT_IDX_W-1:0] granted_reg, granted_next;
    logic                  success_reg, success_next;
    logic                  freed_reg, freed_next;
    logic [REF_OUT_W-1:0]  count_reg, count_next;

    logic [CAP_W-1:0]      cap_eff;
    logic [7:0]            lsb_flags;
    logic [2:0]            lsb_index;
    logic [7:0]            byte_flags;
    logic [SLOT_W-1:0]     slot_in;
    logic [SLOT_W-1:0]     grant_slot;
    logic [BIT_IDX_W-1:0]  grant_bit;
    logic [WORD_BITS-1:0]  slot_word;
    logic [BIT_IDX_W-1:0]  slot_bit;
    logic                  slot_is_free;
    logic                  slot_alloc;
    logic [COUNT_BITS-1:0] cnt_new;

    logic                  fm_we;
    logic [WORD_BITS-1:0]  fm_waddr, fm_raddr;
    logic [63:0]           fm_wdata, fm_rdata;
    logic                  rc_we;
    logic [SLOT_W-1:0]     rc_waddr;
    logic [COUNT_BITS-1:0] rc_wdata, rc_rdata;

    rbsa_ram #(
        .WIDTH (64),
        .DEPTH (MAP_WORDS)
    ) u_free_map (
        .clk   (clk),
        .we    (fm_we),
        .waddr (fm_waddr),
        .wdata (fm_wdata),
        .raddr (fm_raddr),
        .rdata (fm_rdata)
    );

    rbsa_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_SLOTS)
    ) u_ref_counts (
        .clk   (clk),
        .we    (rc_we),
        .waddr (rc_waddr),
        .wdata (rc_wdata),
        .raddr (slot_in),
        .rdata (rc_rdata)
    );

    rbsa_lsb8 u_lsb (
        .flags (lsb_flags),
        .index (lsb_index)
    );

    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CAP_W'(1);
        end
        else if (32'(cap_reg) > 32'(MAP_WORDS))
        begin
            cap_eff = CAP_W'(MAP_WORDS);
        end
        else
        begin
            cap_eff = cap_reg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            byte_flags[i] = |data_reg[8*i +: 8];
        end
    end

    assign lsb_flags    = (state_reg == ST_FIND1) ? byte_flags : byte_reg;
    assign slot_in      = SLOT_W'(slot_index);
    assign grant_bit    = {byte_idx_reg, lsb_index};
    assign grant_slot   = {word_reg, grant_bit};
    assign slot_word    = slot_reg[SLOT_W-1:BIT_IDX_W];
    assign slot_bit     = slot_reg[BIT_IDX_W-1:0];
    assign slot_is_free = fm_rdata[slot_bit];
    assign slot_alloc   = !slot_is_free && (32'(slot_word) < 32'(cap_eff));
    assign cnt_new      = (cmd_reg == CMD_DROP) ? (rc_rdata - COUNT_BITS'(1))
                                                : (rc_rdata + COUNT_BITS'(1));

    always_comb
    begin
        fm_raddr = (state_reg == ST_SCAN) ? (word_reg + WORD_BITS'(1)) : search_reg;
        if (state_reg == ST_IDLE && command != CMD_ALLOC)
        begin
            fm_raddr = slot_in[SLOT_W-1:BIT_IDX_W];
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        search_next   = search_reg;
        used_next     = used_reg;
        clr_next      = clr_reg;
        word_next     = word_reg;
        cmd_next      = cmd_reg;
        slot_next     = slot_reg;
        data_next     = data_reg;
        byte_idx_next = byte_idx_reg;
        byte_next     = byte_reg;
        done_next     = 1'b0;
        granted_next  = granted_reg;
        success_next  = success_reg;
        freed_next    = freed_reg;
        count_next    = count_reg;
        fm_we         = 1'b0;
        fm_waddr      = clr_reg;
        fm_wdata      = '1;
        rc_we         = 1'b0;
        rc_waddr      = grant_slot;
        rc_wdata      = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                fm_we = 1'b1;
                clr_next = clr_reg + WORD_BITS'(1);
                if (clr_reg == WORD_BITS'(MAP_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next = command;
                    slot_next = slot_in;
                    granted_next = '0;
                    success_next = 1'b0;
                    freed_next = 1'b0;
                    count_next = '0;
                    if (command == CMD_ALLOC)
                    begin
                        word_next = search_reg;
                        if (used_reg == {cap_eff, 6'b0}
                            || 32'(search_reg) >= 32'(cap_eff))
                        begin
                            done_next = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                    else if (32'(slot_index) >= 32'(NUM_SLOTS))
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_OPRD;
                    end
                end
            end
            ST_SCAN:
            begin
                if (fm_rdata != '0)
                begin
                    data_next = fm_rdata;
                    state_next = ST_FIND1;
                end
                else if (32'(word_reg) + 32'd1 >= 32'(cap_eff))
                begin
                    done_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    word_next = word_reg + WORD_BITS'(1);
                end
            end
            ST_FIND1:
            begin
                byte_idx_next = lsb_index;
                byte_next = data_reg[8*lsb_index +: 8];
                state_next = ST_FIND2;
            end
            ST_FIND2:
            begin
                fm_we = 1'b1;
                fm_waddr = word_reg;
                fm_wdata = data_reg & ~(64'd1 << grant_bit);
                rc_we = 1'b1;
                search_next = word_reg;
                used_next = used_reg + USED_W'(1);
                granted_next = SLOT_IDX_W'(grant_slot);
                success_next = 1'b1;
                done_next = 1'b1;
                state_next = ST_IDLE;
            end
            ST_OPRD:
            begin
                rc_waddr = slot_reg;
                rc_wdata = cnt_new;
                fm_waddr = slot_word;
                fm_wdata = fm_rdata | (64'd1 << slot_bit);
                success_next = slot_alloc;
                count_next = slot_is_free ? '0 : REF_OUT_W'(rc_rdata);
                if (slot_alloc)
                begin
                    case (cmd_reg)
                        CMD_ADD, CMD_DROP:
                        begin
                            rc_we = 1'b1;
                            count_next = REF_OUT_W'(cnt_new);
                            if (cmd_reg == CMD_DROP && cnt_new == '0)
                            begin
                                fm_we = 1'b1;
                                search_next = slot_word;
                                used_next = used_reg - USED_W'(1);
                                freed_next = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                done_next = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            cap_reg    <= CAP_RESET;
            search_reg <= '0;
            used_reg   <= '0;
            clr_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            search_reg <= search_next;
            used_reg   <= used_next;
            clr_reg    <= clr_next;
            done_reg   <= done_next;
            if (capacity_words_we)
            begin
                cap_reg <= capacity_words;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg     <= word_next;
        cmd_reg      <= cmd_next;
        slot_reg     <= slot_next;
        data_reg     <= data_next;
        byte_idx_reg <= byte_idx_next;
        byte_reg     <= byte_next;
        granted_reg  <= granted_next;
        success_reg  <= success_next;
        freed_reg    <= freed_next;
        count_reg    <= count_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign granted_slot  = granted_reg;
    assign success       = success_reg;
    assign slot_freed    = freed_reg;
    assign ref_count_now = count_reg;

endmodule

// ===== sv/rbsa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the free bitmap and the reference counts; depends on nothing.
module rbsa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/rbsa_lsb8.sv =====
// Shared lowest-set-bit finder over eight flags.
// Used twice per allocation: once on byte flags, once on the chosen byte.
module rbsa_lsb8 (
    input  logic [7:0] flags,
    output logic [2:0] index
);

    always_comb
    begin
        index = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (flags[i])
            begin
                index = 3'(i);
            end
        end
    end

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the reference-counted bitmap slot allocator.
// Drives command transfers against a cycle-free predictor of the slot state.
// Depends on rbsa_pkg and refcounted_bitmap_slot_allocator.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rbsa_pkg::*;

    localparam int NUM_SLOTS      = MAP_WORDS_DEF * WORD_SLOTS;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [SLOT_IDX_W-1:0] slot;
        logic                  ok;
        logic                  freed;
        logic [REF_OUT_W-1:0]  count;
    } alloc_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  capacity_words_we;
    logic [CAP_W-1:0]      capacity_words;
    logic                  start;
    logic                  busy;
    logic [CMD_W-1:0]      command;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic                  done;
    logic [SLOT_IDX_W-1:0] granted_slot;
    logic                  success;
    logic                  slot_freed;
    logic [REF_OUT_W-1:0]  ref_count_now;

    logic [WORD_SLOTS-1:0] model_free_map [MAP_WORDS_DEF];
    logic [REF_OUT_W-1:0]  model_refcnt [NUM_SLOTS];
    logic [3:0]            model_hint;
    logic [USED_W-1:0]     model_used;
    logic [CAP_W-1:0]      model_cap;

    alloc_result_t pending_results[$];
    alloc_result_t checked_result;
    int            held_slots[$];

    bit no_gaps;
    int error_count;
    int n_sent;
    int n_checked;
    int n_grants;
    int n_alloc_fail;
    int n_frees;
    int n_cap_writes;
    int idle_cycles;

    refcounted_bitmap_slot_allocator i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .capacity_words_we (capacity_words_we),
        .capacity_words    (capacity_words),
        .start             (start),
        .busy              (busy),
        .command           (command),
        .slot_index        (slot_index),
        .done              (done),
        .granted_slot      (granted_slot),
        .success           (success),
        .slot_freed        (slot_freed),
        .ref_count_now     (ref_count_now)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic predict_command(input logic [CMD_W-1:0] cmd,
                                   input logic [SLOT_IDX_W-1:0] slot);
        int            words;
        int            w;
        int            b;
        int            i;
        logic          held;
        alloc_result_t r;
        begin
            r = '0;
            words = (model_cap == 0) ? 1 :
                    ((model_cap > MAP_WORDS_DEF) ? MAP_WORDS_DEF : int'(model_cap));
            if (cmd == CMD_ALLOC)
            begin
                if (model_used != words * WORD_SLOTS)
                begin
                    for (w = model_hint; w < words && !r.ok; w++)
                    begin
                        if (model_free_map[w] != '0)
                        begin
                            b = 0;
                            while (!model_free_map[w][b])
                                b++;
                            r.slot = SLOT_IDX_W'(w * WORD_SLOTS + b);
                            model_free_map[w][b] = 1'b0;
                            model_hint = w[3:0];
                            model_used = model_used + 1'b1;
                            r.ok = 1'b1;
                            r.count = model_refcnt[r.slot];
                            held_slots.push_back(int'(r.slot));
                            n_grants++;
                        end
                    end
                end
                if (!r.ok)
                    n_alloc_fail++;
            end
            else
            begin
                w = int'(slot[SLOT_IDX_W-1:BIT_IDX_W]);
                held = (w < words) && !model_free_map[w][slot[BIT_IDX_W-1:0]];
                r.ok = held;
                if (held && cmd == CMD_ADD)
                begin
                    model_refcnt[slot] = model_refcnt[slot] + 1'b1;
                end
                else if (held && cmd == CMD_DROP)
                begin
                    model_refcnt[slot] = model_refcnt[slot] - 1'b1;
                    if (model_refcnt[slot] == 0)
                    begin
                        model_free_map[w][slot[BIT_IDX_W-1:0]] = 1'b1;
                        model_hint = w[3:0];
                        model_used = model_used - 1'b1;
                        r.freed = 1'b1;
                        n_frees++;
                        for (i = 0; i < held_slots.size(); i++)
                        begin
                            if (held_slots[i] == int'(slot))
                            begin
                                held_slots.delete(i);
                                break;
                            end
                        end
                    end
                end
                r.count = model_refcnt[slot];
            end
            pending_results.push_back(r);
        end
    endtask

    task automatic send_command(input logic [CMD_W-1:0] cmd,
                                input logic [SLOT_IDX_W-1:0] slot);
        int r;
        int gap;
        begin
            r = $urandom_range(0, 99);
            if (no_gaps || r < 60)
                gap = 0;
            else if (r < 90)
                gap = $urandom_range(1, 3);
            else if (r < 97)
                gap = $urandom_range(4, 10);
            else
                gap = $urandom_range(20, 60);
            if (gap > 0)
            begin
                @(negedge clk);
                start <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            start      <= 1'b1;
            command    <= cmd;
            slot_index <= slot;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            predict_command(cmd, slot);
            n_sent++;
        end
    endtask

    task automatic wait_idle;
        begin
            @(negedge clk);
            start <= 1'b0;
            while (pending_results.size() != 0 || busy)
                @(posedge clk);
        end
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        begin
            wait_idle();
            @(negedge clk);
            capacity_words_we <= 1'b1;
            capacity_words    <= value;
            @(negedge clk);
            capacity_words_we <= 1'b0;
            model_cap = value;
            n_cap_writes++;
        end
    endtask

    task automatic random_command(input int alloc_pct);
        int                    r;
        logic [SLOT_IDX_W-1:0] s;
        logic [CMD_W-1:0]      c;
        begin
            r = $urandom_range(0, 99);
            s = SLOT_IDX_W'($urandom_range(0, NUM_SLOTS - 1));
            if (r < alloc_pct)
            begin
                c = CMD_ALLOC;
            end
            else if (held_slots.size() != 0 && r < 90)
            begin
                s = SLOT_IDX_W'(held_slots[$urandom_range(0, held_slots.size() - 1)]);
                r = $urandom_range(0, 99);
                if (model_refcnt[s] == 0)
                    c = (r < 80) ? CMD_ADD : ((r < 90) ? CMD_DROP : CMD_QUERY);
                else
                    c = (r < 45) ? CMD_ADD : ((r < 90) ? CMD_DROP : CMD_QUERY);
            end
            else
            begin
                c = CMD_W'($urandom_range(CMD_ALLOC, CMD_QUERY));
            end
            send_command(c, s);
        end
    endtask

    task automatic test_unallocated_slots;
        begin
            send_command(CMD_QUERY, '0);
            send_command(CMD_QUERY, '1);
            send_command(CMD_ADD, SLOT_IDX_W'(5));
            send_command(CMD_DROP, '1);
        end
    endtask

    task automatic test_reference_counting;
        logic [SLOT_IDX_W-1:0] s;
        begin
            send_command(CMD_ALLOC, '1);
            s = SLOT_IDX_W'(held_slots[$]);
            send_command(CMD_ADD, s);
            send_command(CMD_ADD, s);
            send_command(CMD_QUERY, s);
            send_command(CMD_DROP, s);
            send_command(CMD_DROP, s);
            send_command(CMD_ALLOC, '0);
            s = SLOT_IDX_W'(held_slots[$]);
            send_command(CMD_DROP, s);
            send_command(CMD_ADD, s);
            send_command(CMD_ADD, s);
            send_command(CMD_DROP, s);
        end
    endtask

    task automatic test_capacity_extremes;
        begin
            write_capacity('1);
            send_command(CMD_ALLOC, '0);
            send_command(CMD_ADD, SLOT_IDX_W'(held_slots[$]));
            send_command(CMD_QUERY, '1);
            write_capacity(CAP_RESET);
        end
    endtask

    task automatic test_fill_and_shrink;
        int                    tries;
        logic [SLOT_IDX_W-1:0] s;
        begin
            write_capacity(CAP_W'(1));
            repeat (180) random_command(70);
            write_capacity(CAP_W'(2));
            tries = 0;
            while (model_hint == 0 && tries < 140)
            begin
                send_command(CMD_ALLOC, SLOT_IDX_W'($urandom_range(0, NUM_SLOTS - 1)));
                tries++;
            end
            s = SLOT_IDX_W'(held_slots[$]);
            write_capacity('0);
            send_command(CMD_ALLOC, '0);
            send_command(CMD_QUERY, s);
            send_command(CMD_ADD, s);
            send_command(CMD_DROP, s);
        end
    endtask

    task automatic test_random_traffic(input logic [CAP_W-1:0] cap, input int items,
                                       input bit quiet);
        begin
            write_capacity(cap);
            no_gaps = quiet;
            repeat (items) random_command(35);
            no_gaps = 1'b0;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("ERROR: unexpected result slot=%0d success=%0b freed=%0b count=%0d",
                             granted_slot, success, slot_freed, ref_count_now);
            end
            else
            begin
                checked_result = pending_results.pop_front();
                n_checked++;
                if (granted_slot !== checked_result.slot || success !== checked_result.ok ||
                    slot_freed !== checked_result.freed ||
                    ref_count_now !== checked_result.count)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                    begin
                        $display("ERROR: result %0d expected slot=%0d success=%0b %s%0d count=%0d",
                                 n_checked, checked_result.slot, checked_result.ok,
                                 "freed=", checked_result.freed, checked_result.count);
                        $display("       got slot=%0d success=%0b freed=%0b count=%0d",
                                 granted_slot, success, slot_freed, ref_count_now);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("ERROR: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        capacity_words_we = 1'b0;
        capacity_words    = CAP_RESET;
        start             = 1'b0;
        command           = CMD_QUERY;
        slot_index        = '0;
        no_gaps           = 1'b0;
        for (int w = 0; w < MAP_WORDS_DEF; w++)
            model_free_map[w] = '1;
        for (int s = 0; s < NUM_SLOTS; s++)
            model_refcnt[s] = '0;
        model_hint = '0;
        model_used = '0;
        model_cap  = CAP_RESET;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);

        test_unallocated_slots();
        test_reference_counting();
        test_capacity_extremes();
        test_fill_and_shrink();
        test_random_traffic(CAP_RESET, 200, 1'b0);
        test_random_traffic(CAP_W'(3), 200, 1'b1);
        test_random_traffic('1, 200, 1'b0);
        test_random_traffic('0, 200, 1'b0);
        test_random_traffic(CAP_W'($urandom_range(1, MAP_WORDS_DEF)), 200, 1'b1);
        test_random_traffic(CAP_W'($urandom_range(MAP_WORDS_DEF + 1, 31)), 200, 1'b0);
        test_random_traffic(CAP_W'(2), 200, 1'b0);

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Checked %0d results for %0d commands: %0d grants, %0d failed allocations.",
                 n_checked, n_sent, n_grants, n_alloc_fail);
        $display("Freed %0d slots; capacity was rewritten %0d times, %s",
                 n_frees, n_cap_writes, "including both out-of-range settings.");
        if (error_count == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
